// File: sv/assert_macros.svh
// Assertion macros used by the RTL file.
// Each macro takes a label, a clock, an active-low reset, and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/tbcd_pkg.sv
`default_nettype none

package tbcd_pkg;

    // Widths of the configuration channel and the stream payloads.
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 8;
    localparam int CNT_W       = 8;
    localparam int MODE_W      = 3;

    typedef logic [MODE_W-1:0]     t_mode;
    typedef logic [CNT_W-1:0]      t_count;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // Configuration register indexes.
    localparam t_cfg_idx REG_PRESSED_LEVEL  = 1'd0;
    localparam t_cfg_idx REG_DEBOUNCE_TICKS = 1'd1;

    // Configuration reset values.
    localparam logic   PRESSED_LEVEL_RST  = 1'b0;
    localparam t_count DEBOUNCE_TICKS_RST = 8'd10;

    // Qualification modes.
    localparam t_mode MODE_IDLE     = 3'd0;
    localparam t_mode MODE_TO_LEFT  = 3'd1;
    localparam t_mode MODE_TO_RIGHT = 3'd2;
    localparam t_mode MODE_ENTER    = 3'd3;
    localparam t_mode MODE_E_LEFT   = 3'd4;
    localparam t_mode MODE_E_RIGHT  = 3'd5;

endpackage

`default_nettype wire

// File: sv/two_button_chord_debouncer.sv
// Channel | Direction | Handshake              | Payload
// s_axis  | in        | i_s_tvalid/o_s_tready  | tdata[0] left_level, [1] right_level
// m_axis  | out       | o_m_tvalid/i_m_tready  | tdata[0] left, [1] right, [2] enter event
// cfg     | in        | i_cfg_valid/o_cfg_ready| index 0 pressed_level, 1 debounce_ticks
//
// One pin sample per cycle is accepted while the output is not stalled; a sample
// is registered, then the mode/countdown update and the result register are written
// when the result slot frees up, so throughput is set by that single update stage.
// Reset (synchronous, active low) returns to idle with a zero countdown and the
// default configuration. A stalled output holds its result and the input register
// keeps one more sample before the input side is stalled as well.
`default_nettype none

`include "assert_macros.svh"

module two_button_chord_debouncer (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Input stream: [0] left_level, [1] right_level, upper bits zero.
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    input  wire  [tbcd_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // Output stream: [0] left_event, [1] right_event, [2] enter_event, upper bits zero.
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    output logic [tbcd_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // Configuration write channel.
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [tbcd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [tbcd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tbcd_pkg::*;

    // Configuration registers.
    logic   r_pressed_level;
    t_count r_debounce_ticks;

    // Input register stage.
    logic r_s1_valid;
    logic r_s1_left;
    logic r_s1_right;

    // Qualification state.
    t_mode  r_mode,  n_mode;
    t_count r_count, n_count;

    // Result register.
    logic r_out_valid;
    logic r_out_left,  n_out_left;
    logic r_out_right, n_out_right;
    logic r_out_enter, n_out_enter;

    logic   s1_move;
    logic   held_l;
    logic   held_r;
    t_mode  mode_in;
    t_count count_dec;

    // The configuration port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed_level  <= PRESSED_LEVEL_RST;
            r_debounce_ticks <= DEBOUNCE_TICKS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PRESSED_LEVEL:  r_pressed_level  <= i_cfg_data[0];
                REG_DEBOUNCE_TICKS: r_debounce_ticks <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage handshakes: the registered sample moves on when the result slot frees up.
    assign s1_move    = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_s1_left  <= i_s_tdata[0];
            r_s1_right <= i_s_tdata[1];
        end
    end

    // Mode and countdown update for one sample.
    assign held_l    = (r_s1_left  == r_pressed_level);
    assign held_r    = (r_s1_right == r_pressed_level);
    assign mode_in   = (r_mode > MODE_E_RIGHT) ? MODE_IDLE : r_mode;
    assign count_dec = (r_count != '0) ? (r_count - t_count'(1)) : r_count;

    always_comb begin
        n_mode      = mode_in;
        n_count     = r_count;
        n_out_left  = 1'b0;
        n_out_right = 1'b0;
        n_out_enter = 1'b0;
        if (held_l && held_r) begin
            // Chord: enter on every tick both are held.
            n_mode      = MODE_ENTER;
            n_out_enter = 1'b1;
        end else if (!held_l && !held_r) begin
            // Release reports a pending lone press.
            n_out_left  = (mode_in == MODE_TO_LEFT);
            n_out_right = (mode_in == MODE_TO_RIGHT);
            n_mode      = MODE_IDLE;
        end else if (held_l) begin
            case (mode_in)
                MODE_IDLE, MODE_E_RIGHT: begin
                    n_mode  = MODE_TO_LEFT;
                    n_count = r_debounce_ticks;
                end
                MODE_TO_LEFT: begin
                    n_count    = count_dec;
                    n_out_left = (count_dec == '0);
                end
                MODE_TO_RIGHT: begin
                    n_mode      = MODE_TO_LEFT;
                    n_count     = r_debounce_ticks;
                    n_out_right = 1'b1;
                end
                MODE_ENTER: begin
                    n_mode = MODE_E_LEFT;
                end
                default: ;
            endcase
        end else begin
            case (mode_in)
                MODE_IDLE, MODE_E_LEFT: begin
                    n_mode  = MODE_TO_RIGHT;
                    n_count = r_debounce_ticks;
                end
                MODE_TO_LEFT: begin
                    n_mode     = MODE_TO_RIGHT;
                    n_count    = r_debounce_ticks;
                    n_out_left = 1'b1;
                end
                MODE_TO_RIGHT: begin
                    n_count     = count_dec;
                    n_out_right = (count_dec == '0);
                end
                MODE_ENTER: begin
                    n_mode = MODE_E_RIGHT;
                end
                default: ;
            endcase
        end
    end

    // State and result valid advance together with each transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_move) begin
                r_mode  <= n_mode;
                r_count <= n_count;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_left  <= n_out_left;
            r_out_right <= n_out_right;
            r_out_enter <= n_out_enter;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W-3){1'b0}}, r_out_enter, r_out_right, r_out_left};

    // At most one event is reported per result.
    `ASSERT_IMPL(a_one_event, i_clk, i_rst_n, r_out_valid,
        $onehot0({r_out_left, r_out_right, r_out_enter}))
    // A stalled result freezes the qualification state.
    `ASSERT_NEXT(a_stall_holds_state, i_clk, i_rst_n, r_out_valid && !i_m_tready,
        $stable(r_mode) && $stable(r_count))
    // A waiting enter result always matches the enter mode it left behind.
    `ASSERT_IMPL(a_enter_mode, i_clk, i_rst_n, r_out_valid && r_out_enter,
        r_mode == MODE_ENTER)
    // A moved sample is always visible as a result in the next cycle.
    `ASSERT_NEXT(a_move_shows, i_clk, i_rst_n, s1_move, r_out_valid)

endmodule

`default_nettype wire

// File: tb/tb_two_button_chord_debouncer.sv
`timescale 1ns / 100ps

module tb_two_button_chord_debouncer;
    import tbcd_pkg::*;

    // Qualified events that one pin sample should produce.
    typedef struct {
        bit left;
        bit right;
        bit enter;
    } t_chord_events;

    // Tracks the mode and countdown of the block and checks each result.
    class chord_scoreboard;
        bit            active_level = PRESSED_LEVEL_RST;
        t_count        hold_ticks   = DEBOUNCE_TICKS_RST;
        t_mode         mode         = MODE_IDLE;
        t_count        countdown    = '0;
        t_chord_events pending_events[$];
        int unsigned   errors       = 0;

        task report(string what);
            errors++;
            $display("%0t ns mismatch: %s", $time, what);
        endtask

        function int unsigned pending();
            return pending_events.size();
        endfunction

        function void write_register(t_cfg_idx index, t_cfg_data value);
            case (index)
                REG_PRESSED_LEVEL:  active_level = value[0];
                REG_DEBOUNCE_TICKS: hold_ticks = value;
                default: ;
            endcase
        endfunction

        // Advances the mode for one accepted sample and queues its events.
        function void note_sample(bit left_lvl, bit right_lvl);
            bit            l_held;
            bit            r_held;
            t_mode         m;
            t_chord_events ev;
            l_held = (left_lvl == active_level);
            r_held = (right_lvl == active_level);
            ev = '{left: 1'b0, right: 1'b0, enter: 1'b0};
            m = mode;
            if (m > MODE_E_RIGHT) begin
                m = MODE_IDLE;
            end
            if (l_held && r_held) begin
                m = MODE_ENTER;
                ev.enter = 1'b1;
            end else if (!l_held && !r_held) begin
                // A release reports a press that was still being qualified.
                if (m == MODE_TO_LEFT) begin
                    ev.left = 1'b1;
                end else if (m == MODE_TO_RIGHT) begin
                    ev.right = 1'b1;
                end
                m = MODE_IDLE;
            end else if (l_held) begin
                case (m)
                    MODE_IDLE, MODE_E_RIGHT: begin
                        m = MODE_TO_LEFT;
                        countdown = hold_ticks;
                    end
                    MODE_TO_LEFT: begin
                        if (countdown != 0) begin
                            countdown = countdown - 1'b1;
                        end
                        ev.left = (countdown == 0);
                    end
                    MODE_TO_RIGHT: begin
                        m = MODE_TO_LEFT;
                        countdown = hold_ticks;
                        ev.right = 1'b1;
                    end
                    MODE_ENTER: m = MODE_E_LEFT;
                    default: ;
                endcase
            end else begin
                case (m)
                    MODE_IDLE, MODE_E_LEFT: begin
                        m = MODE_TO_RIGHT;
                        countdown = hold_ticks;
                    end
                    MODE_TO_RIGHT: begin
                        if (countdown != 0) begin
                            countdown = countdown - 1'b1;
                        end
                        ev.right = (countdown == 0);
                    end
                    MODE_TO_LEFT: begin
                        m = MODE_TO_RIGHT;
                        countdown = hold_ticks;
                        ev.left = 1'b1;
                    end
                    MODE_ENTER: m = MODE_E_RIGHT;
                    default: ;
                endcase
            end
            mode = m;
            pending_events.push_back(ev);
        endfunction

        task check_result(logic [OUT_DATA_W-1:0] tdata);
            t_chord_events want;
            if (pending_events.size() == 0) begin
                report($sformatf("result 0x%h with no sample waiting", tdata));
                return;
            end
            want = pending_events.pop_front();
            if (tdata[0] !== want.left) begin
                report($sformatf("left_event %b, wanted %b", tdata[0], want.left));
            end
            if (tdata[1] !== want.right) begin
                report($sformatf("right_event %b, wanted %b", tdata[1], want.right));
            end
            if (tdata[2] !== want.enter) begin
                report($sformatf("enter_event %b, wanted %b", tdata[2], want.enter));
            end
            if (tdata[OUT_DATA_W-1:3] !== '0) begin
                report($sformatf("padding bits of result 0x%h not zero", tdata));
            end
        endtask
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b1;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index = '0;
    t_cfg_data             i_cfg_data  = '0;

    chord_scoreboard sb = new();

    // Level that currently means pressed, as last written to the block.
    bit active_level = PRESSED_LEVEL_RST;
    bit src_idle_on  = 1'b1;
    bit snk_idle_on  = 1'b1;

    two_button_chord_debouncer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Check every result transaction on the output stream.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata);
        end
    end

    // The receiver stalls in random bursts while idling is enabled.
    initial begin
        forever begin
            @(posedge i_clk);
            if (snk_idle_on && $urandom_range(0, 9) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end
        end
    end

    // Sends one pin sample and records it once the transaction completes.
    task automatic send_sample(input bit left_lvl, input bit right_lvl);
        if (src_idle_on && $urandom_range(0, 7) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_DATA_W-2){1'b0}}, right_lvl, left_lvl};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_sample(left_lvl, right_lvl);
    endtask

    // Sends a sample given as held buttons: bit 0 left, bit 1 right.
    task automatic send_held(input bit [1:0] held);
        send_sample(held[0] ? active_level : ~active_level,
                    held[1] ? active_level : ~active_level);
    endtask

    // Stops sending and waits for every outstanding result.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Presents one register write and waits for its transaction; the caller drops valid.
    task automatic write_register(input t_cfg_idx index, input t_cfg_data value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_register(index, value);
        if (index == REG_PRESSED_LEVEL) begin
            active_level = value[0];
        end
    endtask

    // Writes both registers once the block has gone idle.
    task automatic set_config(input bit level, input t_count ticks);
        wait_drained();
        write_register(REG_PRESSED_LEVEL, {7'($urandom), level});
        write_register(REG_DEBOUNCE_TICKS, ticks);
        i_cfg_valid <= 1'b0;
    endtask

    // Random press patterns, often held long enough to reach the countdown end.
    task automatic run_phase(input bit level, input t_count ticks,
                             input int unsigned budget, input bit idle_on);
        int unsigned sent;
        int unsigned len;
        int unsigned pick;
        bit [1:0]    held;
        set_config(level, ticks);
        src_idle_on = idle_on;
        snk_idle_on = idle_on;
        sent = 0;
        while (sent < budget) begin
            held = 2'($urandom);
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                len = ticks + $urandom_range(0, 3);
            end else if (pick < 7) begin
                len = $urandom_range(1, 3);
            end else if (pick < 9) begin
                len = $urandom_range(1, ticks + 6);
            end else begin
                // Contact bounce: one stray sample.
                len = 1;
            end
            if (len == 0) begin
                len = 1;
            end
            // The phase stops at its budget.
            if (len > budget - sent) begin
                len = budget - sent;
            end
            repeat (len) send_held(held);
            sent += len;
            if ($urandom_range(0, 149) == 0) begin
                wait_drained();
            end
        end
    endtask

    initial begin
        t_count ticks;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: low level means pressed.
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b0);

        // Short countdown, high level means pressed.
        set_config(1'b1, 8'd2);
        send_held(2'b00);
        repeat (4) send_held(2'b01);
        send_held(2'b10);
        send_held(2'b01);
        send_held(2'b00);
        send_held(2'b11);
        repeat (2) send_held(2'b01);
        repeat (2) send_held(2'b10);
        send_held(2'b11);
        send_held(2'b10);
        send_held(2'b01);
        send_held(2'b11);
        send_held(2'b00);

        // Zero countdown reports on the tick after the press.
        set_config(1'b0, 8'd0);
        repeat (3) send_held(2'b10);
        send_held(2'b00);
        send_held(2'b01);
        send_held(2'b00);

        // Longest countdown, then a spread of settings; the last phase runs flat out.
        run_phase(1'b0, 8'd255, 540, 1'b1);
        for (int p = 1; p < 8; p++) begin
            case (p)
                1: ticks = 8'd0;
                2: ticks = 8'd1;
                3: ticks = 8'd3;
                4: ticks = 8'd7;
                5: ticks = 8'd2;
                6: ticks = 8'($urandom_range(0, 20));
                default: ticks = 8'd5;
            endcase
            run_phase(p[0], ticks, 170, (p % 3 != 2) && (p != 7));
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("two_button_chord_debouncer verification clean");
        end else begin
            $display("two_button_chord_debouncer verification failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20_000_000;
        $display("two_button_chord_debouncer verification failed");
        $finish;
    end

endmodule
